@@ rtl/core/bpf_pkg.sv @@
// Package for the basis-point fee block: widths, constants, beat types.
// No dependencies; used by bpf_mul and basis_point_fee_and_inverse.
package bpf_pkg;

  localparam int AMOUNT_BITS = 48;
  localparam int OUT_BITS    = 47;
  localparam int RATE_BITS   = 16;
  localparam int PROD_BITS   = OUT_BITS + RATE_BITS;
  localparam int LH_BITS     = OUT_BITS + 1;
  localparam int EXT_BITS    = (AMOUNT_BITS > OUT_BITS) ? AMOUNT_BITS : OUT_BITS;

  localparam int BPS_DIV     = 10000;
  localparam int RATE_STEP   = 10;
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  localparam int ACC_BITS       = 64;
  localparam int FEE_PRE_SHIFT  = 14;
  localparam int FEE_POST_SHIFT = 47;
  localparam int FEE_TAIL_SHIFT = FEE_POST_SHIFT - 2 * RATE_BITS;
  localparam int FEE_REM_MAX    = 4 * BPS_DIV;
  localparam logic [3*RATE_BITS-1:0] FEE_RECIP =
    (3*RATE_BITS)'((64'd1 << (FEE_PRE_SHIFT + FEE_POST_SHIFT)) / 64'(BPS_DIV));

  localparam logic [OUT_BITS-1:0]  MAX_OUT_RESET  = OUT_BITS'(64'd100000000000);
  localparam logic [RATE_BITS-1:0] MAX_RATE_RESET = RATE_BITS'(1000);

  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = OUT_BITS;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_OUT  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_RATE = 1'b1;

  localparam logic OP_FEE     = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  typedef struct packed {
    logic                           op;
    logic signed [AMOUNT_BITS-1:0]  amount;
    logic        [RATE_BITS-1:0]    rate_bps;
  } in_beat_t;

  typedef struct packed {
    logic                ok;
    logic [OUT_BITS-1:0] value;
  } out_beat_t;

endpackage

@@ rtl/core/basis_point_fee_and_inverse.sv @@
// Basis-point fee and inverse: top level with sequencer around one shared multiplier.
// Depends on bpf_pkg and bpf_mul.
// A failed argument check goes straight to the result beat; op 0 computes the fee and ends early
// when the fee overflows; op 1 searches for the payment by bisection, at most 47 probes.
// Throughput: one item at a time; next beat accepted once the result is loaded.
// Reset (rst_n, synchronous): idle, no result pending, limits back to defaults.
module basis_point_fee_and_inverse
  import bpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_beat_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_beat_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDIV, S_CHK, S_FMUL, S_FOVR, S_FOVC, S_FQ1, S_FQ2,
    S_FQ3, S_FRM, S_FADJ, S_PPRB, S_PM1, S_PM2, S_PM3, S_EMIT
  } state_t;

  state_t               state_r;
  logic [OUT_BITS-1:0]  max_out_r;
  logic [RATE_BITS-1:0] max_rate_r;
  logic                 op_r;
  logic                 amt_bad_r;
  logic [OUT_BITS-1:0]  mag_r;
  logic [RATE_BITS-1:0] rate_r;
  logic [OUT_BITS-1:0]  cm_r;
  logic [LH_BITS-1:0]   lo_r;
  logic [LH_BITS-1:0]   hi_r;
  logic [OUT_BITS-1:0]  mid_r;
  logic [PROD_BITS-1:0] p_r;
  logic [ACC_BITS-1:0]  acc_r;
  logic                 res_ok_r;
  logic [OUT_BITS-1:0]  res_val_r;
  logic                 out_valid_r;
  out_beat_t            out_data_r;

  logic [OUT_BITS-1:0]    mul_a;
  logic [RATE_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]   prod_r;
  logic [AMOUNT_BITS-1:0] raw;
  logic [EXT_BITS-1:0]    raw_ext;
  logic                   amt_bad;
  logic [LH_BITS:0]       lh_sum;
  logic [OUT_BITS-1:0]    mid_calc;
  logic [RATE_BITS-1:0]   q10;
  logic [RATE_BITS+3:0]   q10_x10;
  logic                   rate_bad;
  logic [PROD_BITS:0]     p_plus;
  logic [PROD_BITS:0]     t_ext;
  logic [OUT_BITS-1:0]    p_hi;
  logic [ACC_BITS-1:0]    acc_sum;
  logic [PROD_BITS-1:0]   fee_rem;
  logic [2:0]             fee_up;

  assign raw      = in_data.amount;
  assign raw_ext  = EXT_BITS'(raw);
  assign amt_bad  = raw[AMOUNT_BITS-1] || (raw == '0) || (raw_ext > EXT_BITS'(max_out_r));
  assign lh_sum   = (LH_BITS+1)'(lo_r) + (LH_BITS+1)'(hi_r);
  assign mid_calc = OUT_BITS'(lh_sum >> 1);
  assign q10      = RATE_BITS'(prod_r >> DIV10_SHIFT);
  assign q10_x10  = ((RATE_BITS+4)'(q10) << 3) + ((RATE_BITS+4)'(q10) << 1);
  assign rate_bad = (rate_r > max_rate_r) || (q10_x10 != (RATE_BITS+4)'(rate_r));
  assign p_plus   = (PROD_BITS+1)'(p_r) + (PROD_BITS+1)'(BPS_DIV);
  assign t_ext    = (PROD_BITS+1)'(prod_r);
  assign p_hi     = OUT_BITS'(p_r >> FEE_PRE_SHIFT);
  assign acc_sum  = (acc_r >> RATE_BITS) + ACC_BITS'(prod_r);
  assign fee_rem  = p_r - prod_r;
  assign fee_up   = 3'(fee_rem != '0) + 3'(fee_rem > PROD_BITS'(BPS_DIV))
                  + 3'(fee_rem > PROD_BITS'(2 * BPS_DIV))
                  + 3'(fee_rem > PROD_BITS'(3 * BPS_DIV));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_RDIV: begin
        mul_a = OUT_BITS'(rate_r);
        mul_b = RATE_BITS'(DIV10_MUL);
      end
      S_FMUL: begin
        mul_a = mag_r;
        mul_b = rate_r;
      end
      S_FOVR: begin
        mul_a = cm_r;
        mul_b = RATE_BITS'(BPS_DIV);
      end
      S_FOVC: begin
        mul_a = p_hi;
        mul_b = FEE_RECIP[RATE_BITS-1:0];
      end
      S_FQ1: begin
        mul_a = p_hi;
        mul_b = FEE_RECIP[2*RATE_BITS-1:RATE_BITS];
      end
      S_FQ2: begin
        mul_a = p_hi;
        mul_b = FEE_RECIP[3*RATE_BITS-1:2*RATE_BITS];
      end
      S_FRM: begin
        mul_a = mid_r;
        mul_b = RATE_BITS'(BPS_DIV);
      end
      S_PPRB: begin
        mul_a = mid_calc;
        mul_b = rate_r;
      end
      S_PM1: begin
        mul_a = max_out_r - mid_r;
        mul_b = RATE_BITS'(BPS_DIV);
      end
      S_PM2: begin
        mul_a = mag_r - mid_r;
        mul_b = RATE_BITS'(BPS_DIV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bpf_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      max_out_r   <= MAX_OUT_RESET;
      max_rate_r  <= MAX_RATE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MAX_OUT:  max_out_r  <= OUT_BITS'(cfg_wdata);
          CFG_MAX_RATE: max_rate_r <= RATE_BITS'(cfg_wdata);
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_data.op;
            amt_bad_r <= amt_bad;
            mag_r     <= OUT_BITS'(raw);
            rate_r    <= in_data.rate_bps;
            state_r   <= S_RDIV;
          end
        end
        S_RDIV: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          cm_r <= max_out_r - mag_r;
          lo_r <= LH_BITS'(1);
          hi_r <= LH_BITS'(mag_r);
          if (amt_bad_r || rate_bad) begin
            res_ok_r  <= 1'b0;
            res_val_r <= '0;
            state_r   <= S_EMIT;
          end else if (op_r == OP_FEE) begin
            state_r <= S_FMUL;
          end else begin
            state_r <= S_PPRB;
          end
        end
        S_FMUL: begin
          state_r <= S_FOVR;
        end
        S_FOVR: begin
          p_r     <= prod_r;
          state_r <= S_FOVC;
        end
        S_FOVC: begin
          if (p_r > prod_r) begin
            res_ok_r  <= 1'b0;
            res_val_r <= '0;
            state_r   <= S_EMIT;
          end else begin
            state_r <= S_FQ1;
          end
        end
        S_FQ1: begin
          acc_r   <= ACC_BITS'(prod_r);
          state_r <= S_FQ2;
        end
        S_FQ2: begin
          acc_r   <= acc_sum;
          state_r <= S_FQ3;
        end
        S_FQ3: begin
          mid_r   <= OUT_BITS'(acc_sum >> FEE_TAIL_SHIFT);
          state_r <= S_FRM;
        end
        S_FRM: begin
          state_r <= S_FADJ;
        end
        S_FADJ: begin
          res_ok_r  <= 1'b1;
          res_val_r <= mid_r + OUT_BITS'(fee_up);
          state_r   <= S_EMIT;
        end
        S_PPRB: begin
          mid_r <= mid_calc;
          if (lo_r > hi_r) begin
            res_ok_r  <= 1'b0;
            res_val_r <= '0;
            state_r   <= S_EMIT;
          end else begin
            state_r <= S_PM1;
          end
        end
        S_PM1: begin
          p_r     <= prod_r;
          state_r <= S_PM2;
        end
        S_PM2: begin
          if (p_r > prod_r) begin
            hi_r    <= LH_BITS'(mid_r) - LH_BITS'(1);
            state_r <= S_PPRB;
          end else begin
            state_r <= S_PM3;
          end
        end
        S_PM3: begin
          priority if (p_plus <= t_ext) begin
            lo_r    <= LH_BITS'(mid_r) + LH_BITS'(1);
            state_r <= S_PPRB;
          end else if (p_r <= prod_r) begin
            res_ok_r  <= 1'b1;
            res_val_r <= mid_r;
            state_r   <= S_EMIT;
          end else begin
            hi_r    <= LH_BITS'(mid_r) - LH_BITS'(1);
            state_r <= S_PPRB;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r      <= 1'b1;
            out_data_r.ok    <= res_ok_r;
            out_data_r.value <= res_val_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.ok) |-> (out_data_r.value == '0))
    else $error("rejected beat carries nonzero value");

  a_ok_below_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.ok) |-> (out_data_r.value <= max_out_r))
    else $error("accepted value above ceiling");

  a_fee_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FADJ) |-> (prod_r <= p_r && fee_rem <= PROD_BITS'(FEE_REM_MAX)))
    else $error("fee quotient estimate out of range");

  a_inv_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PPRB) |-> (hi_r <= LH_BITS'(mag_r)))
    else $error("payment search upper bound above gross");

  a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

endmodule

@@ rtl/core/bpf_mul.sv @@
// Shared registered multiplier: OUT_BITS x RATE_BITS, product held in a register.
// Depends on bpf_pkg.
module bpf_mul
  import bpf_pkg::*;
(
  input  logic                 clk,
  input  logic [OUT_BITS-1:0]  mul_a,
  input  logic [RATE_BITS-1:0] mul_b,
  output logic [PROD_BITS-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
  end

endmodule
